>>> sv/tkpt_pkg.sv
// Shared types and constants for the top-k peak tracker.
package tkpt_pkg;

  // Number of entries the sorted list can hold.
  localparam int CAPACITY = 8;
  // Slot address width and held-count width.
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // Fixed field widths of the ports.
  localparam int FREQ_W  = 32;
  localparam int LEVEL_W = 16;
  localparam int RANK_W  = 3;
  localparam int COUNT_W = 4;
  // Width used when comparing a requested rank against the count.
  localparam int CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

  // Request codes.
  localparam logic [1:0] REQ_OBSERVE = 2'd0;
  localparam logic [1:0] REQ_READ    = 2'd1;
  localparam logic [1:0] REQ_CLEAR   = 2'd2;

  // One list entry.
  typedef struct packed {
    logic [FREQ_W-1:0]         freq;
    logic signed [LEVEL_W-1:0] level;
  } slot_t;

  // Write command from the sequencer to the slot file.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    slot_t            data;
  } slot_wr_t;

endpackage

>>> sv/tkpt_slot_file.sv
// Slot register file: one write port and one read port for the sorted list.
module tkpt_slot_file
  import tkpt_pkg::*;
(
  input  logic             clk,
  input  slot_wr_t         wr,
  input  logic [IDX_W-1:0] rd_addr,
  output slot_t            rd_data
);

  slot_t slots [CAPACITY];

  // Entries are written by the sequencer; contents are undefined until written.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      slots[wr.addr] <= wr.data;
    end
  end

  // Single read address chosen by the sequencer.
  assign rd_data = slots[rd_addr];

endmodule

>>> sv/top_k_peak_tracker.sv
// Top level of the top-k peak tracker: sequencer, held count and result register.
// Read, clear and unused codes go from acceptance straight to the report state, which loads the result.
// An observe walks the list once to find the frequency, may check the weakest entry when the list
// is full, then moves the entry up one rank per cycle until it stands in its place.
// One transaction is taken at a time, and each one steps through the single read port of the slot
// file. Reset empties the list; slot contents are not cleared.
module top_k_peak_tracker
  import tkpt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  logic [1:0]                req_type,
  input  logic [FREQ_W-1:0]         frequency,
  input  logic signed [LEVEL_W-1:0] level,
  input  logic [RANK_W-1:0]         entry_index,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output logic                      entry_valid,
  output logic [FREQ_W-1:0]         entry_frequency,
  output logic signed [LEVEL_W-1:0] entry_level,
  output logic [COUNT_W-1:0]        entry_count
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_CHECK  = 5'b00100,
    ST_SHIFT  = 5'b01000,
    ST_REPORT = 5'b10000
  } state_t;

  state_t                    state, state_next;
  logic [1:0]                req_q;
  logic [RANK_W-1:0]         rank_q;
  logic [FREQ_W-1:0]         cur_freq;
  logic signed [LEVEL_W-1:0] cur_level, cur_level_next;
  logic [CNT_W-1:0]          ptr, ptr_next;
  logic [CNT_W-1:0]          count, count_next;
  logic [CNT_W-1:0]          ptr_dec;
  logic [IDX_W-1:0]          rd_addr;
  logic [RANK_W-1:0]         rep_rank;
  logic                      rep_valid;
  logic                      rsp_load;
  logic                      moves_before;
  slot_t                     rd_data;
  slot_wr_t                  wr;

  tkpt_slot_file u_slots (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign req_ready = (state == ST_IDLE);
  assign ptr_dec   = ptr - CNT_W'(1);

  // Rank reported by this transaction and whether that entry exists.
  assign rep_rank  = (req_q == REQ_READ) ? rank_q : RANK_W'(0);
  assign rep_valid = CMP_W'(rep_rank) < CMP_W'(count);
  assign rsp_load  = (state == ST_REPORT) && (!rsp_valid || rsp_ready);

  // The held entry ranks before the one just above the hole.
  assign moves_before = ($signed(cur_level) > $signed(rd_data.level)) ||
                        (($signed(cur_level) == $signed(rd_data.level)) &&
                         (cur_freq < rd_data.freq));

  // Read address of the slot file for the current step.
  always_comb begin
    unique case (state)
      ST_SCAN:   rd_addr = ptr[IDX_W-1:0];
      ST_CHECK:  rd_addr = IDX_W'(CAPACITY - 1);
      ST_SHIFT:  rd_addr = ptr_dec[IDX_W-1:0];
      ST_REPORT: rd_addr = IDX_W'(rep_rank);
      default:   rd_addr = '0;
    endcase
  end

  // Sequencer: scan for the frequency, decide the hole, then bubble the entry up.
  always_comb begin
    state_next     = state;
    ptr_next       = ptr;
    count_next     = count;
    cur_level_next = cur_level;
    wr             = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          ptr_next       = '0;
          cur_level_next = level;
          if (req_type == REQ_OBSERVE) begin
            state_next = ST_SCAN;
          end else begin
            if (req_type == REQ_CLEAR) begin
              count_next = '0;
            end
            state_next = ST_REPORT;
          end
        end
      end
      ST_SCAN: begin
        if (ptr == count) begin
          // Frequency not held: append, or contest the weakest entry.
          if (count < CNT_W'(CAPACITY)) begin
            count_next = count + CNT_W'(1);
            state_next = ST_SHIFT;
          end else begin
            state_next = ST_CHECK;
          end
        end else if (rd_data.freq == cur_freq) begin
          if ($signed(rd_data.level) > $signed(cur_level)) begin
            cur_level_next = rd_data.level;
          end
          state_next = ST_SHIFT;
        end else begin
          ptr_next = ptr + CNT_W'(1);
        end
      end
      ST_CHECK: begin
        if ($signed(cur_level) > $signed(rd_data.level)) begin
          ptr_next   = CNT_W'(CAPACITY - 1);
          state_next = ST_SHIFT;
        end else begin
          state_next = ST_REPORT;
        end
      end
      ST_SHIFT: begin
        wr.en   = 1'b1;
        wr.addr = ptr[IDX_W-1:0];
        if ((ptr != '0) && moves_before) begin
          wr.data  = rd_data;
          ptr_next = ptr_dec;
        end else begin
          wr.data.freq  = cur_freq;
          wr.data.level = cur_level;
          state_next    = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (rsp_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Transaction payload and working registers.
  always_ff @(posedge clk) begin
    ptr       <= ptr_next;
    cur_level <= cur_level_next;
    if (req_valid && req_ready) begin
      req_q    <= req_type;
      rank_q   <= entry_index;
      cur_freq <= frequency;
    end
  end

  // Result register, held until the response transaction completes.
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      entry_valid     <= rep_valid;
      entry_frequency <= rep_valid ? rd_data.freq : '0;
      entry_level     <= rep_valid ? rd_data.level : '0;
      entry_count     <= COUNT_W'(count);
    end
  end

  // The list never holds more than its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("held count exceeds capacity");

  // A clear empties the list at once.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && (req_type == REQ_CLEAR)) |=> (count == '0))
    else $error("clear did not empty the list");

  // A reported entry implies a nonempty list.
  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && entry_valid) |-> (entry_count != '0))
    else $error("valid entry reported with empty list");

  // The scan pointer never runs past the held entries.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (ptr <= count))
    else $error("scan pointer beyond held count");

endmodule

>>> dv/top_k_peak_tracker_test.sv
// Self-checking testbench for the top-k peak tracker: directed table, then random traffic.
module top_k_peak_tracker_test
  import tkpt_pkg::*;
;

  // The request code that the block leaves unused.
  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_ITEMS = 1100;
  localparam int FREQ_POOL = 12;
  localparam int LEVEL_POOL = 6;
  localparam int SETTLE_CYCLES = 2 * CAPACITY + 8;

  // One reported entry, as the response fields carry it.
  typedef struct packed {
    logic                      valid;
    logic [FREQ_W-1:0]         freq;
    logic signed [LEVEL_W-1:0] level;
    logic [COUNT_W-1:0]        count;
  } peak_report_t;

  // One row of the directed table; a typed-in report is used only when has_report is set.
  typedef struct packed {
    logic [1:0]                req;
    logic [FREQ_W-1:0]         freq;
    logic signed [LEVEL_W-1:0] level;
    logic [RANK_W-1:0]         rank;
    logic                      has_report;
    peak_report_t              report;
  } stim_row_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      req_valid;
  logic                      req_ready;
  logic [1:0]                req_type;
  logic [FREQ_W-1:0]         frequency;
  logic signed [LEVEL_W-1:0] level;
  logic [RANK_W-1:0]         entry_index;
  logic                      rsp_valid;
  logic                      rsp_ready;
  logic                      entry_valid;
  logic [FREQ_W-1:0]         entry_frequency;
  logic signed [LEVEL_W-1:0] entry_level;
  logic [COUNT_W-1:0]        entry_count;

  top_k_peak_tracker dut (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req_type       (req_type),
    .frequency      (frequency),
    .level          (level),
    .entry_index    (entry_index),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .entry_valid    (entry_valid),
    .entry_frequency(entry_frequency),
    .entry_level    (entry_level),
    .entry_count    (entry_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predicted list contents, kept sorted by level descending, then frequency ascending.
  logic [FREQ_W-1:0]         peak_freq [CAPACITY];
  logic signed [LEVEL_W-1:0] peak_level [CAPACITY];
  int                        peak_count;

  peak_report_t pending_reports [$];
  int           error_count;
  bit           steady_phase;
  logic [FREQ_W-1:0]         freq_pool [FREQ_POOL];
  logic signed [LEVEL_W-1:0] level_pool [LEVEL_POOL];

  // Directed table: empty list, field extremes, dedup, full list, equal-level drop, clear.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{REQ_READ,    32'h0,        16'sh0,    3'd0, 1'b1, '{1'b0, 32'h0, 16'sh0, 4'd0}},
    '{REQ_READ,    32'h0,        16'sh0,    3'd7, 1'b1, '{1'b0, 32'h0, 16'sh0, 4'd0}},
    '{REQ_SPARE,   32'hFFFFFFFF, 16'sh7FFF, 3'd7, 1'b1, '{1'b0, 32'h0, 16'sh0, 4'd0}},
    '{REQ_CLEAR,   32'hFFFFFFFF, 16'sh8000, 3'd0, 1'b1, '{1'b0, 32'h0, 16'sh0, 4'd0}},
    '{REQ_OBSERVE, 32'h0,        16'sh8000, 3'd0, 1'b1, '{1'b1, 32'h0, 16'sh8000, 4'd1}},
    '{REQ_OBSERVE, 32'hFFFFFFFF, 16'sh7FFF, 3'd0, 1'b1,
      '{1'b1, 32'hFFFFFFFF, 16'sh7FFF, 4'd2}},
    '{REQ_OBSERVE, 32'h0,        16'sh7FFF, 3'd0, 1'b1, '{1'b1, 32'h0, 16'sh7FFF, 4'd2}},
    '{REQ_READ,    32'h0,        16'sh0,    3'd1, 1'b1,
      '{1'b1, 32'hFFFFFFFF, 16'sh7FFF, 4'd2}},
    '{REQ_OBSERVE, 32'hFFFFFFFF, 16'sh8000, 3'd0, 1'b1, '{1'b1, 32'h0, 16'sh7FFF, 4'd2}},
    '{REQ_OBSERVE, 32'd100,      -16'sd1000, 3'd0, 1'b0, '0},
    '{REQ_OBSERVE, 32'd101,      -16'sd1,    3'd0, 1'b0, '0},
    '{REQ_OBSERVE, 32'd102,      16'sd0,     3'd0, 1'b0, '0},
    '{REQ_OBSERVE, 32'd103,      16'sd0,     3'd0, 1'b0, '0},
    '{REQ_OBSERVE, 32'd104,      16'sd256,   3'd0, 1'b0, '0},
    '{REQ_OBSERVE, 32'd105,      -16'sd1000, 3'd0, 1'b0, '0},
    '{REQ_OBSERVE, 32'd300,      -16'sd1000, 3'd0, 1'b1, '{1'b1, 32'h0, 16'sh7FFF, 4'd8}},
    '{REQ_READ,    32'h0,        16'sh0,     3'd7, 1'b0, '0},
    '{REQ_OBSERVE, 32'd301,      -16'sd999,  3'd0, 1'b0, '0},
    '{REQ_READ,    32'h0,        16'sh0,     3'd7, 1'b0, '0},
    '{REQ_OBSERVE, 32'd301,      16'sh7FFF,  3'd0, 1'b0, '0},
    '{REQ_READ,    32'h0,        16'sh0,     3'd1, 1'b0, '0},
    '{REQ_SPARE,   32'd999,      16'sh7FFF,  3'd3, 1'b0, '0},
    '{REQ_CLEAR,   32'h0,        16'sh0,     3'd0, 1'b1, '{1'b0, 32'h0, 16'sh0, 4'd0}},
    '{REQ_READ,    32'h0,        16'sh0,     3'd0, 1'b1, '{1'b0, 32'h0, 16'sh0, 4'd0}},
    '{REQ_OBSERVE, 32'd5,        16'sh8000,  3'd0, 1'b1, '{1'b1, 32'd5, 16'sh8000, 4'd1}}
  };

  // True when slot a belongs ahead of slot b in the list.
  function automatic bit outranks(int a, int b);
    if (peak_level[a] != peak_level[b]) return peak_level[a] > peak_level[b];
    return peak_freq[a] < peak_freq[b];
  endfunction

  // Insertion sort over the held entries.
  function automatic void resort_peaks();
    logic [FREQ_W-1:0]         f;
    logic signed [LEVEL_W-1:0] l;
    for (int i = 1; i < peak_count; i++) begin
      for (int j = i; j > 0 && outranks(j, j - 1); j--) begin
        f = peak_freq[j];
        l = peak_level[j];
        peak_freq[j] = peak_freq[j - 1];
        peak_level[j] = peak_level[j - 1];
        peak_freq[j - 1] = f;
        peak_level[j - 1] = l;
      end
    end
  endfunction

  // Fold one observation into the list: raise a known frequency, append, or evict the weakest.
  function automatic void observe_peak(logic [FREQ_W-1:0] f, logic signed [LEVEL_W-1:0] l);
    for (int i = 0; i < peak_count; i++) begin
      if (peak_freq[i] == f) begin
        if (l > peak_level[i]) peak_level[i] = l;
        resort_peaks();
        return;
      end
    end
    if (peak_count < CAPACITY) begin
      peak_freq[peak_count] = f;
      peak_level[peak_count] = l;
      peak_count++;
    end else if (l > peak_level[CAPACITY - 1]) begin
      peak_freq[CAPACITY - 1] = f;
      peak_level[CAPACITY - 1] = l;
    end else begin
      return;
    end
    resort_peaks();
  endfunction

  // Apply one request to the predicted list and return the entry it reports.
  function automatic peak_report_t track_item(logic [1:0] req, logic [FREQ_W-1:0] f,
                                              logic signed [LEVEL_W-1:0] l,
                                              logic [RANK_W-1:0] rank);
    peak_report_t rep;
    int           pick;
    if (req == REQ_OBSERVE) observe_peak(f, l);
    else if (req == REQ_CLEAR) peak_count = 0;
    pick = (req == REQ_READ) ? int'(rank) : 0;
    rep.valid = (pick < peak_count);
    rep.freq = rep.valid ? peak_freq[pick] : '0;
    rep.level = rep.valid ? peak_level[pick] : '0;
    rep.count = peak_count[COUNT_W-1:0];
    return rep;
  endfunction

  // Offer one request transaction; called at a falling edge and returns at one.
  task automatic send_request(logic [1:0] req, logic [FREQ_W-1:0] f,
                              logic signed [LEVEL_W-1:0] l, logic [RANK_W-1:0] rank,
                              logic has_report, peak_report_t typed_report);
    peak_report_t predicted;
    while (!steady_phase && $urandom_range(99) < 30) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_type <= req;
    frequency <= f;
    level <= l;
    entry_index <= rank;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predicted = track_item(req, f, l, rank);
    pending_reports.push_back(has_report ? typed_report : predicted);
    @(negedge clk);
  endtask

  // Random request: mostly observations over a small pool of frequencies so that
  // duplicates, ties and a full list are common; rare clears let the list refill.
  task automatic pick_random_request(output logic [1:0] req, output logic [FREQ_W-1:0] f,
                                     output logic signed [LEVEL_W-1:0] l,
                                     output logic [RANK_W-1:0] rank);
    int roll;
    roll = $urandom_range(99);
    if (roll < 62) req = REQ_OBSERVE;
    else if (roll < 92) req = REQ_READ;
    else if (roll < 96) req = REQ_CLEAR;
    else req = REQ_SPARE;
    f = ($urandom_range(99) < 80) ? freq_pool[$urandom_range(FREQ_POOL - 1)] : $urandom;
    roll = $urandom_range(99);
    if (roll < 40) l = level_pool[$urandom_range(LEVEL_POOL - 1)];
    else if (roll < 50) l = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    else l = LEVEL_W'($urandom_range(16'hFFFF));
    rank = RANK_W'($urandom_range(7));
  endtask

  // Response side: stalls at random except during the steady stretch.
  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ready <= steady_phase || ($urandom_range(99) >= 30);
    end
  end

  // Compare every accepted response transaction with the oldest expectation.
  always @(posedge clk) begin : check_results
    peak_report_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_reports.size() == 0) begin
        $error("response with no request outstanding");
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        if (entry_valid !== want.valid) begin
          $error("entry_valid: expected %0d, actual %0d", want.valid, entry_valid);
          error_count++;
        end
        if (entry_frequency !== want.freq) begin
          $error("entry_frequency: expected %h, actual %h", want.freq, entry_frequency);
          error_count++;
        end
        if (entry_level !== want.level) begin
          $error("entry_level: expected %0d, actual %0d", want.level, entry_level);
          error_count++;
        end
        if (entry_count !== want.count) begin
          $error("entry_count: expected %0d, actual %0d", want.count, entry_count);
          error_count++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    logic [1:0]                r_req;
    logic [FREQ_W-1:0]         r_freq;
    logic signed [LEVEL_W-1:0] r_level;
    logic [RANK_W-1:0]         r_rank;
    rst = 1'b1;
    req_valid = 1'b0;
    req_type = REQ_OBSERVE;
    frequency = '0;
    level = '0;
    entry_index = '0;
    error_count = 0;
    steady_phase = 1'b0;
    peak_count = 0;
    foreach (freq_pool[i]) freq_pool[i] = $urandom;
    foreach (level_pool[i]) level_pool[i] = LEVEL_W'($urandom_range(16'hFFFF));
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].freq, directed_rows[i].level,
                   directed_rows[i].rank, directed_rows[i].has_report,
                   directed_rows[i].report);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady_phase = (n >= 500 && n < 700);
      // Now and then hold off until every outstanding response has come back.
      if (n % 250 == 249) begin
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending_reports.size() != 0) @(negedge clk);
      end
      pick_random_request(r_req, r_freq, r_level, r_rank);
      send_request(r_req, r_freq, r_level, r_rank, 1'b0, '0);
    end
    req_valid <= 1'b0;
    steady_phase = 1'b0;

    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $error("%0d expected responses never arrived", pending_reports.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("top_k_peak_tracker_test passed");
    end else begin
      $display("top_k_peak_tracker_test failed");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #(400_000 * 20);
    $display("top_k_peak_tracker_test failed");
    $finish;
  end

endmodule
